// ===== rtl/core/cba_pkg.sv =====
// ----------------------------------------------------------------------------
// cba_pkg
// Shared types and constants of the contiguous block allocator.
// ----------------------------------------------------------------------------
package cba_pkg;

	localparam int CNT_W   = 24;
	localparam int BB_W    = 16;
	localparam int BIU_W   = 9;
	localparam int IDX_W   = 8;
	localparam int DIV_W   = 26;
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;

	localparam logic [1:0] MODE_ALLOC  = 2'd0;
	localparam logic [1:0] MODE_FREE   = 2'd1;
	localparam logic [1:0] MODE_SHRINK = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_NOSPACE = 2'd2;
	localparam logic [1:0] ST_NOTUSED = 2'd3;

	localparam logic REG_BLOCK_BYTES   = 1'b0;
	localparam logic REG_BLOCKS_IN_USE = 1'b1;

	localparam logic [BB_W-1:0]  BB_RESET  = 16'd64;
	localparam logic [BIU_W-1:0] BIU_RESET = 9'd256;

	typedef struct packed {
		logic [1:0]       mode;
		logic [CNT_W-1:0] byte_count;
		logic [IDX_W-1:0] start_block;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [IDX_W-1:0] buf_start;
		logic [CNT_W-1:0] granted_bytes;
		logic [BIU_W-1:0] blocks_released;
	} rsp_t;

endpackage

// ===== rtl/core/contiguous_block_allocator.sv =====
// ----------------------------------------------------------------------------
// contiguous_block_allocator
// First-fit allocator of contiguous block runs over a usage bitmap in RAM.
// ----------------------------------------------------------------------------
// Steps: allocate divides, scans the bitmap block by block and marks the
// blocks taken (a zero-size request also grows into the free blocks that
// follow); free and shrink divide, check and release, and a shrink divides twice.
// Throughput: one transaction at a time; the bitmap RAM visits each block in a read
// state and an evaluate state, and the divider yields one quotient bit per cycle.
// Reset: a clearing pass over min(POOL_DEPTH, 256) entries zeroes both RAMs.
module contiguous_block_allocator #(
	parameter int POOL_DEPTH   = 256,
	parameter int HEADER_BYTES = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  cba_pkg::req_t              req,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output cba_pkg::rsp_t              rsp,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [cba_pkg::APB_AW-1:0] paddr,
	input  logic [cba_pkg::APB_DW-1:0] pwdata,
	output logic [cba_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);
	import cba_pkg::*;

	localparam int MEM_D = (POOL_DEPTH < 256) ? POOL_DEPTH : 256;
	localparam int AW    = $clog2(MEM_D);

	localparam logic [4:0] S_CLR    = 5'd0;
	localparam logic [4:0] S_IDLE   = 5'd1;
	localparam logic [4:0] S_DECODE = 5'd2;
	localparam logic [4:0] S_DIVA   = 5'd3;
	localparam logic [4:0] S_SCANRD = 5'd4;
	localparam logic [4:0] S_SCANEV = 5'd5;
	localparam logic [4:0] S_MARK   = 5'd6;
	localparam logic [4:0] S_EXTRD  = 5'd7;
	localparam logic [4:0] S_EXTEV  = 5'd8;
	localparam logic [4:0] S_GMUL   = 5'd9;
	localparam logic [4:0] S_GSUB   = 5'd10;
	localparam logic [4:0] S_SZEV   = 5'd11;
	localparam logic [4:0] S_RANGE  = 5'd12;
	localparam logic [4:0] S_DIVF   = 5'd13;
	localparam logic [4:0] S_DIVS   = 5'd14;
	localparam logic [4:0] S_CHKRD  = 5'd15;
	localparam logic [4:0] S_CHKEV  = 5'd16;
	localparam logic [4:0] S_FREE   = 5'd17;
	localparam logic [4:0] S_DONE   = 5'd18;

	logic [4:0]       state_q;
	logic [BB_W-1:0]  bb_q;
	logic [BIU_W-1:0] biu_q;
	req_t             req_q;
	rsp_t             res_q;
	rsp_t             rsp_q;
	logic             rsp_valid_q;

	logic [BIU_W-1:0] ptr_q;
	logic [BIU_W-1:0] run_q;
	logic [BIU_W-1:0] n_q;
	logic [BIU_W-1:0] s_q;
	logic [BIU_W-1:0] first_q;
	logic [BIU_W-1:0] end_q;
	logic [CNT_W-1:0] size_q;
	logic [CNT_W-1:0] prod_a_q;
	logic [CNT_W:0]   prod_b_q;
	logic [CNT_W:0]   gmul_q;

	logic [BIU_W-1:0] c_w;
	logic [BIU_W-1:0] ptr_inc;
	logic [BIU_W-1:0] run_nx;
	logic             u_bit;
	logic [CNT_W-1:0] size_rdata;
	logic             bad_req;
	logic             quo_gt_c;
	logic             quo_gt_n;
	logic [DIV_W:0]   range_lhs;
	logic [CNT_W-1:0] granted_w;
	rsp_t             err_res;

	logic             usage_we;
	logic             usage_wd;
	logic             size_we;
	logic [AW-1:0]    size_waddr;
	logic [CNT_W-1:0] size_wdata;

	logic             div_start;
	logic             div_done;
	logic [DIV_W-1:0] div_dvd;
	logic [DIV_W-1:0] quo;
	logic [CNT_W-1:0] div_x;

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_BLOCKS_IN_USE) ? APB_DW'(biu_q) : APB_DW'(bb_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bb_q  <= BB_RESET;
			biu_q <= BIU_RESET;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_BLOCKS_IN_USE) begin
				biu_q <= pwdata[BIU_W-1:0];
			end else begin
				bb_q <= pwdata[BB_W-1:0];
			end
		end
	end

	assign c_w     = (biu_q < BIU_W'(MEM_D)) ? biu_q : BIU_W'(MEM_D);
	assign ptr_inc = ptr_q + 1'b1;
	assign run_nx  = u_bit ? '0 : run_q + 1'b1;
	assign bad_req = (bb_q == '0) ||
		!(req_q.mode inside {MODE_ALLOC, MODE_FREE, MODE_SHRINK});
	assign quo_gt_c = quo > DIV_W'(c_w);
	assign quo_gt_n = quo > DIV_W'(n_q);
	assign range_lhs = (DIV_W+1)'(prod_a_q) + (DIV_W+1)'(HEADER_BYTES) + (DIV_W+1)'(size_q);
	assign granted_w = CNT_W'(gmul_q - (CNT_W+1)'(HEADER_BYTES));

	// error code depends on where the request gave up
	always_comb begin
		err_res           = '0;
		err_res.buf_start = (req_q.mode == MODE_ALLOC) ? '0 : req_q.start_block;
		case (state_q)
			S_SCANEV: err_res.status = ST_NOSPACE;
			S_CHKEV:  err_res.status = ST_NOTUSED;
			default:  err_res.status = ST_INVALID;
		endcase
	end

	// divider operand: stored size during range check, request size otherwise
	assign div_x   = (state_q == S_RANGE) ? size_q : req_q.byte_count;
	assign div_dvd = DIV_W'(div_x) + DIV_W'(HEADER_BYTES) + DIV_W'(bb_q) - 1'b1;

	always_comb begin
		div_start = 1'b0;
		case (state_q)
			S_DECODE: div_start = !bad_req && (req_q.mode == MODE_ALLOC);
			S_RANGE:  div_start = range_lhs <= (DIV_W+1)'(prod_b_q);
			S_DIVF:   div_start = div_done && (req_q.mode == MODE_SHRINK);
			default:  div_start = 1'b0;
		endcase
	end

	always_comb begin
		usage_we = 1'b0;
		usage_wd = 1'b0;
		case (state_q)
			S_CLR:   usage_we = 1'b1;
			S_MARK:  begin
				usage_we = 1'b1;
				usage_wd = 1'b1;
			end
			S_EXTEV: begin
				usage_we = !u_bit;
				usage_wd = 1'b1;
			end
			S_FREE:  usage_we = 1'b1;
			default: usage_we = 1'b0;
		endcase
	end

	always_comb begin
		size_we    = 1'b0;
		size_waddr = req_q.start_block[AW-1:0];
		size_wdata = req_q.byte_count;
		case (state_q)
			S_CLR: begin
				size_we    = 1'b1;
				size_waddr = ptr_q[AW-1:0];
				size_wdata = '0;
			end
			S_GSUB: begin
				size_we    = 1'b1;
				size_waddr = s_q[AW-1:0];
				size_wdata = granted_w;
			end
			S_DIVS:  size_we = div_done && !quo_gt_n;
			default: size_we = 1'b0;
		endcase
	end

	cba_ram #(.WIDTH(1), .DEPTH(MEM_D)) u_usage (
		.clk   (clk),
		.we    (usage_we),
		.waddr (ptr_q[AW-1:0]),
		.wdata (usage_wd),
		.raddr (ptr_q[AW-1:0]),
		.rdata (u_bit)
	);

	cba_ram #(.WIDTH(CNT_W), .DEPTH(MEM_D)) u_size (
		.clk   (clk),
		.we    (size_we),
		.waddr (size_waddr),
		.wdata (size_wdata),
		.raddr (req_q.start_block[AW-1:0]),
		.rdata (size_rdata)
	);

	cba_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (bb_q),
		.done     (div_done),
		.quotient (quo)
	);

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			ptr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && (!rsp_valid_q || rsp_ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					ptr_q <= ptr_inc;
					if (ptr_q == BIU_W'(MEM_D - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (bad_req) begin
						res_q   <= err_res;
						state_q <= S_DONE;
					end else if (req_q.mode == MODE_ALLOC) begin
						state_q <= S_DIVA;
					end else if (BIU_W'(req_q.start_block) >= c_w) begin
						res_q   <= err_res;
						state_q <= S_DONE;
					end else begin
						state_q <= S_SZEV;
					end
				end
				S_DIVA: begin
					if (div_done) begin
						if (quo_gt_c) begin
							res_q   <= err_res;
							state_q <= S_DONE;
						end else begin
							n_q     <= quo[BIU_W-1:0];
							ptr_q   <= '0;
							run_q   <= '0;
							state_q <= S_SCANRD;
						end
					end
				end
				S_SCANRD: state_q <= S_SCANEV;
				S_SCANEV: begin
					run_q <= run_nx;
					if (run_nx == n_q) begin
						s_q     <= ptr_inc - n_q;
						end_q   <= ptr_inc;
						ptr_q   <= ptr_inc - n_q;
						state_q <= S_MARK;
					end else if (ptr_inc >= c_w) begin
						res_q   <= err_res;
						state_q <= S_DONE;
					end else begin
						ptr_q   <= ptr_inc;
						state_q <= S_SCANRD;
					end
				end
				S_MARK: begin
					ptr_q <= ptr_inc;
					if (ptr_inc == end_q) begin
						if (req_q.byte_count == '0 && end_q < c_w) begin
							state_q <= S_EXTRD;
						end else begin
							state_q <= S_GMUL;
						end
					end
				end
				S_EXTRD: state_q <= S_EXTEV;
				S_EXTEV: begin
					if (!u_bit) begin
						end_q <= ptr_inc;
						ptr_q <= ptr_inc;
						state_q <= (ptr_inc < c_w) ? S_EXTRD : S_GMUL;
					end else begin
						state_q <= S_GMUL;
					end
				end
				S_GMUL: begin
					gmul_q  <= (CNT_W+1)'(bb_q * (end_q - s_q));
					state_q <= S_GSUB;
				end
				S_GSUB: begin
					res_q.status          <= ST_OK;
					res_q.buf_start       <= s_q[IDX_W-1:0];
					res_q.granted_bytes   <= granted_w;
					res_q.blocks_released <= '0;
					state_q               <= S_DONE;
				end
				S_SZEV: begin
					size_q   <= size_rdata;
					prod_a_q <= CNT_W'(req_q.start_block * bb_q);
					prod_b_q <= (CNT_W+1)'(c_w * bb_q);
					state_q  <= S_RANGE;
				end
				S_RANGE: begin
					if (div_start) begin
						state_q <= S_DIVF;
					end else begin
						res_q   <= err_res;
						state_q <= S_DONE;
					end
				end
				S_DIVF: begin
					if (div_done) begin
						n_q <= quo[BIU_W-1:0];
						if (req_q.mode == MODE_SHRINK) begin
							state_q <= S_DIVS;
						end else begin
							first_q <= BIU_W'(req_q.start_block);
							ptr_q   <= BIU_W'(req_q.start_block);
							end_q   <= BIU_W'(req_q.start_block) + quo[BIU_W-1:0];
							state_q <= S_CHKRD;
						end
					end
				end
				S_DIVS: begin
					if (div_done) begin
						if (quo_gt_n) begin
							res_q   <= err_res;
							state_q <= S_DONE;
						end else if (quo[BIU_W-1:0] == n_q) begin
							// nothing to release: size already stored
							res_q.status          <= ST_OK;
							res_q.buf_start       <= req_q.start_block;
							res_q.granted_bytes   <= req_q.byte_count;
							res_q.blocks_released <= '0;
							state_q               <= S_DONE;
						end else begin
							first_q <= BIU_W'(req_q.start_block) + quo[BIU_W-1:0];
							ptr_q   <= BIU_W'(req_q.start_block) + quo[BIU_W-1:0];
							end_q   <= BIU_W'(req_q.start_block) + n_q;
							state_q <= S_CHKRD;
						end
					end
				end
				S_CHKRD: state_q <= S_CHKEV;
				S_CHKEV: begin
					if (!u_bit) begin
						res_q   <= err_res;
						state_q <= S_DONE;
					end else if (ptr_inc == end_q) begin
						ptr_q   <= first_q;
						state_q <= S_FREE;
					end else begin
						ptr_q   <= ptr_inc;
						state_q <= S_CHKRD;
					end
				end
				S_FREE: begin
					ptr_q <= ptr_inc;
					if (ptr_inc == end_q) begin
						res_q.status          <= ST_OK;
						res_q.buf_start       <= req_q.start_block;
						res_q.granted_bytes   <= (req_q.mode == MODE_SHRINK) ?
							req_q.byte_count : '0;
						res_q.blocks_released <= end_q - first_q;
						state_q               <= S_DONE;
					end
				end
				S_DONE: begin
					// hold the result until the output register frees up
					if (!rsp_valid_q || rsp_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			req_q <= req;
		end
		if (state_q == S_DONE && (!rsp_valid_q || rsp_ready)) begin
			rsp_q <= res_q;
		end
	end

endmodule

// ===== rtl/core/cba_ram.sv =====
// ----------------------------------------------------------------------------
// cba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/cba_div.sv =====
// ----------------------------------------------------------------------------
// cba_div
// Restoring divider, one quotient bit per cycle; done pulses for one cycle.
// ----------------------------------------------------------------------------
module cba_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [cba_pkg::DIV_W-1:0]   dividend,
	input  logic [cba_pkg::BB_W-1:0]    divisor,
	output logic                        done,
	output logic [cba_pkg::DIV_W-1:0]   quotient
);
	import cba_pkg::*;

	localparam int CW = $clog2(DIV_W + 1);

	logic            busy_q;
	logic            done_q;
	logic [CW-1:0]   cnt_q;
	logic [DIV_W-1:0] acc_q;
	logic [BB_W-1:0] rem_q;
	logic [BB_W-1:0] dsr_q;
	logic [BB_W:0]   rem_sh;
	logic            ge;
	logic [BB_W:0]   rem_sub;

	assign rem_sh  = {rem_q, acc_q[DIV_W-1]};
	assign ge      = rem_sh >= {1'b0, dsr_q};
	assign rem_sub = rem_sh - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			// shift next dividend bit in, quotient bit out at the bottom
			rem_q <= ge ? rem_sub[BB_W-1:0] : rem_sh[BB_W-1:0];
			acc_q <= {acc_q[DIV_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = acc_q;

endmodule
